// ===== rtl/core/ufx_pkg.sv =====
// Shared types and constants of the parallel UART frame transposer.
package ufx_pkg;

  localparam int SLOTS_PER_BYTE = 10;
  localparam int MARKER_BYTES   = 4;
  localparam int LANES_MAX      = 8;
  localparam int CFG_W          = 10;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [CFG_W-1:0] BPS_RESET = 10'd512;

  // input kinds carried in tuser bit 0
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // baud slot positions inside one 10-slot character
  localparam logic [3:0] POS_START = 4'd0;
  localparam logic [3:0] POS_STOP  = 4'd9;

  // end-of-frame marker, sent on the pin of every stored strip
  localparam logic [7:0] END_MARK [MARKER_BYTES] = '{8'hff, 8'hff, 8'hff, 8'hf0};

  typedef enum logic [0:0] {
    CMD_WRITE,
    CMD_READ
  } cmd_op_t;

  typedef enum logic [1:0] {
    LVL_LOW,
    LVL_HIGH,
    LVL_DATA
  } lvl_src_t;

  // one command from the front end to the back end
  typedef struct packed {
    cmd_op_t    op;
    logic       wr_all;   // strip 0 write: replace whole entry
    logic [2:0] lane;
    logic [7:0] data;
    logic [2:0] bit_sel;
    lvl_src_t   src;
    logic       last;
  } ufx_cmd_t;

  localparam int CMD_W = $bits(ufx_cmd_t);

endpackage

// ===== rtl/core/ufx_front.sv =====
// Front end: accepts items, tracks load/drain position and issues store commands.
module ufx_front import ufx_pkg::*; #(
  parameter int N_STRIPS            = 8,
  parameter int MAX_BYTES_PER_STRIP = 512
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [CFG_W-1:0]                       cfg_data,
  input  logic                                   accept,
  input  logic                                   mode,
  input  logic [7:0]                             data_byte,
  input  logic                                   restart,
  output logic                                   cmd_valid,
  output ufx_cmd_t                               cmd,
  output logic [$clog2(2*MAX_BYTES_PER_STRIP)-1:0] cmd_addr
);

  localparam int LANES = (N_STRIPS < LANES_MAX) ? N_STRIPS : LANES_MAX;
  localparam int SW    = (N_STRIPS > 1) ? $clog2(N_STRIPS) : 1;
  localparam int IW    = $clog2(MAX_BYTES_PER_STRIP);
  localparam int LW    = $clog2(MAX_BYTES_PER_STRIP + 1);
  localparam int BW    = $clog2(MAX_BYTES_PER_STRIP + MARKER_BYTES);
  localparam int AW    = $clog2(2 * MAX_BYTES_PER_STRIP);

  logic [CFG_W-1:0] bps_r;
  logic [SW-1:0]    strip_r, strip_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic             bank_r, bank_nxt;
  logic             pending_r, pending_nxt;
  logic             active_r, active_nxt;
  logic [BW-1:0]    byte_r, byte_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic [LW-1:0]    dlen_r, dlen_nxt;

  logic [LW-1:0]    lim;
  logic [SW-1:0]    strip_v;
  logic [IW-1:0]    idx_v;
  logic [LW-1:0]    idx_inc;
  logic [SW:0]      strip_inc;
  logic             last_v;
  logic [1:0]       mark_sel;
  logic [2:0]       bit_v;

  // saturated frame length
  always_comb begin
    if (bps_r < 10'd2) begin
      lim = LW'(2);
    end else if (32'(bps_r) > 32'(MAX_BYTES_PER_STRIP)) begin
      lim = LW'(MAX_BYTES_PER_STRIP);
    end else begin
      lim = LW'(bps_r);
    end
  end

  always_comb begin
    strip_nxt   = strip_r;
    idx_nxt     = idx_r;
    bank_nxt    = bank_r;
    pending_nxt = pending_r;
    active_nxt  = active_r;
    byte_nxt    = byte_r;
    pos_nxt     = pos_r;
    dlen_nxt    = dlen_r;
    cmd_valid   = 1'b0;
    cmd         = '0;
    cmd_addr    = '0;

    strip_v   = restart ? '0 : strip_r;
    idx_v     = restart ? '0 : idx_r;
    idx_inc   = LW'(idx_v) + LW'(1);
    strip_inc = (SW+1)'(strip_v) + (SW+1)'(1);
    last_v    = (byte_r == BW'(dlen_r) + BW'(MARKER_BYTES - 1)) && (pos_r == POS_STOP);
    mark_sel  = 2'(byte_r - BW'(dlen_r));
    bit_v     = 3'(pos_r - 4'd1);

    if (accept) begin
      if (mode == MODE_LOAD) begin
        strip_nxt = strip_v;
        idx_nxt   = idx_v;
        if (!pending_r) begin
          if (32'(strip_v) < LANES) begin
            cmd_valid  = 1'b1;
            cmd.op     = CMD_WRITE;
            cmd.wr_all = (strip_v == '0);
            cmd.lane   = 3'(strip_v);
            cmd.data   = data_byte;
            cmd_addr   = bank_r ? AW'(MAX_BYTES_PER_STRIP) + AW'(idx_v) : AW'(idx_v);
          end
          if (idx_inc >= lim) begin
            idx_nxt = '0;
            if (32'(strip_inc) >= N_STRIPS) begin
              strip_nxt   = '0;
              pending_nxt = 1'b1;
            end else begin
              strip_nxt = SW'(strip_inc);
            end
          end else begin
            idx_nxt = IW'(idx_inc);
          end
        end
      end else if (active_r) begin
        cmd_valid   = 1'b1;
        cmd.op      = CMD_READ;
        cmd.bit_sel = bit_v;
        cmd.last    = last_v;
        cmd_addr    = !bank_r ? AW'(MAX_BYTES_PER_STRIP) + AW'(byte_r) : AW'(byte_r);
        if (pos_r == POS_START) begin
          cmd.src = LVL_LOW;
        end else if (pos_r == POS_STOP) begin
          cmd.src = LVL_HIGH;
        end else if (byte_r < BW'(dlen_r)) begin
          cmd.src = LVL_DATA;
        end else begin
          cmd.src = END_MARK[mark_sel][bit_v] ? LVL_HIGH : LVL_LOW;
        end
        if (last_v) begin
          active_nxt = 1'b0;
          byte_nxt   = '0;
          pos_nxt    = '0;
        end else if (pos_r == POS_STOP) begin
          pos_nxt  = '0;
          byte_nxt = byte_r + BW'(1);
        end else begin
          pos_nxt = pos_r + 4'd1;
        end
      end
      // bank swap once a loaded frame is pending and no drain runs
      if (pending_nxt && !active_nxt) begin
        dlen_nxt    = lim;
        bank_nxt    = !bank_r;
        pending_nxt = 1'b0;
        active_nxt  = 1'b1;
        byte_nxt    = '0;
        pos_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r     <= BPS_RESET;
      strip_r   <= '0;
      idx_r     <= '0;
      bank_r    <= 1'b0;
      pending_r <= 1'b0;
      active_r  <= 1'b0;
      byte_r    <= '0;
      pos_r     <= '0;
      dlen_r    <= '0;
    end else begin
      if (cfg_we) begin
        bps_r <= cfg_data;
      end
      strip_r   <= strip_nxt;
      idx_r     <= idx_nxt;
      bank_r    <= bank_nxt;
      pending_r <= pending_nxt;
      active_r  <= active_nxt;
      byte_r    <= byte_nxt;
      pos_r     <= pos_nxt;
      dlen_r    <= dlen_nxt;
    end
  end

endmodule

// ===== rtl/core/ufx_queue.sv =====
// Small register FIFO between the front end and the back end.
module ufx_queue #(
  parameter int W     = 32,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (32'(wptr_r) == DEPTH - 1) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (32'(rptr_r) == DEPTH - 1) ? '0 : rptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/ufx_back.sv =====
// Back end: executes store writes and reads, forms pin levels, holds the output register.
module ufx_back import ufx_pkg::*; #(
  parameter int N_STRIPS            = 8,
  parameter int MAX_BYTES_PER_STRIP = 512
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cmd_valid,
  input  ufx_cmd_t                                 cmd,
  input  logic [$clog2(2*MAX_BYTES_PER_STRIP)-1:0] cmd_addr,
  output logic                                     cmd_pop,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [7:0]                               out_pins,
  output logic                                     out_last
);

  localparam int LANES = (N_STRIPS < LANES_MAX) ? N_STRIPS : LANES_MAX;
  localparam int DEPTH = 2 * MAX_BYTES_PER_STRIP;
  localparam logic [7:0] LANE_MASK = 8'((1 << LANES) - 1);

  logic [8*LANES-1:0] mem [DEPTH];
  logic [8*LANES-1:0] rdata_r;

  logic       p1_valid_r;
  lvl_src_t   p1_src_r;
  logic [2:0] p1_bit_r;
  logic       p1_last_r;

  logic       out_valid_r;
  logic [7:0] out_pins_r;
  logic       out_last_r;

  logic       p1_move, p1_free, do_read, do_write;
  logic [7:0] lvl;

  assign p1_move  = p1_valid_r && (!out_valid_r || out_ready);
  assign p1_free  = !p1_valid_r || p1_move;
  assign cmd_pop  = cmd_valid && ((cmd.op == CMD_WRITE) || p1_free);
  assign do_write = cmd_pop && (cmd.op == CMD_WRITE);
  assign do_read  = cmd_pop && (cmd.op == CMD_READ);

  // lane-enabled write; strip 0 clears the other lanes
  always_ff @(posedge clk) begin
    if (do_write) begin
      for (int l = 0; l < LANES; l++) begin
        if (cmd.wr_all || (32'(cmd.lane) == l)) begin
          mem[cmd_addr][8*l +: 8] <= (!cmd.wr_all || l == 0) ? cmd.data : 8'h00;
        end
      end
    end
    if (do_read) begin
      rdata_r <= mem[cmd_addr];
    end
  end

  always_comb begin
    lvl = '0;
    case (p1_src_r)
      LVL_DATA: begin
        for (int k = 0; k < LANES; k++) begin
          lvl[k] = rdata_r[8*k + 32'(p1_bit_r)];
        end
      end
      LVL_HIGH: lvl = LANE_MASK;
      default:  lvl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      p1_src_r  <= cmd.src;
      p1_bit_r  <= cmd.bit_sel;
      p1_last_r <= cmd.last;
    end
    if (p1_move) begin
      out_pins_r <= lvl;
      out_last_r <= p1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_read) begin
        p1_valid_r <= 1'b1;
      end else if (p1_move) begin
        p1_valid_r <= 1'b0;
      end
      if (p1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_pins  = out_pins_r;
  assign out_last  = out_last_r;

endmodule

// ===== rtl/core/parallel_uart_frame_transposer.sv =====
// Top level of the parallel UART frame transposer.
//
// Channels:
//   in_*  : one transaction per item. tuser[0] = mode (0 load byte, 1 drain
//           tick), tuser[1] = restart, tdata = data byte.
//   out_* : one transaction per baud slot. tdata = pin levels (bit k is
//           strip k), tlast = final slot of the frame (stop bit of marker).
//   cfg_* : write of bytes_per_strip; always ready, write only while idle.
// Loads fill one bank of a two-bank frame store strip by strip; when the
// frame is complete and no drain runs, the banks swap and drain ticks read
// out start, data LSB first and stop slots, then a four-byte end marker.
// Throughput: one item per cycle while in_tready is high. The front end updates
// position state at accept; the back end does at most one store access (write
// or read) per cycle. A drain tick's slot passes the queue, the store read
// stage and the output register in that order.
// Reset: load/drain position, bank and pending flags clear, bytes_per_strip
// returns to 512; the store contents are undefined until loaded.
// Stall: when out_tready is low the output and read stage hold; commands
// pile up in the four-entry queue and in_tready drops once it is full.
module parallel_uart_frame_transposer import ufx_pkg::*; #(
  parameter int N_STRIPS            = 8,
  parameter int MAX_BYTES_PER_STRIP = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  input  logic [1:0]       in_tuser,   // [0] mode, [1] restart
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // [7:0] pin_levels
  output logic             out_tlast,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(2 * MAX_BYTES_PER_STRIP);
  localparam int QW = CMD_W + AW;

  logic          accept;
  logic          q_full;
  logic          f_valid;
  ufx_cmd_t      f_cmd;
  logic [AW-1:0] f_addr;
  logic          q_valid, q_pop;
  logic [QW-1:0] q_dout;
  ufx_cmd_t      b_cmd;
  logic [AW-1:0] b_addr;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  ufx_front #(
    .N_STRIPS            (N_STRIPS),
    .MAX_BYTES_PER_STRIP (MAX_BYTES_PER_STRIP)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .mode      (in_tuser[0]),
    .data_byte (in_tdata),
    .restart   (in_tuser[1]),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_addr  (f_addr)
  );

  // commands go through in order, so reads never pass later writes
  ufx_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_valid),
    .din   ({f_cmd, f_addr}),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  assign b_cmd  = q_dout[QW-1:AW];
  assign b_addr = q_dout[AW-1:0];

  ufx_back #(
    .N_STRIPS            (N_STRIPS),
    .MAX_BYTES_PER_STRIP (MAX_BYTES_PER_STRIP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (b_cmd),
    .cmd_addr  (b_addr),
    .cmd_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pins  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// ===== rtl/core/ufx_checker.sv =====
// Port-level checker for the frame transposer, bound to the top level.
module ufx_checker #(
  parameter int N_STRIPS = 8
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       cfg_ready
);

  localparam int LANES = (N_STRIPS < 8) ? N_STRIPS : 8;
  localparam logic [7:0] LANE_MASK = 8'((1 << LANES) - 1);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  // no result straight out of reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // final slot is the marker's stop bit, high on the pin of every stored strip
  a_last_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == LANE_MASK)
    else $error("last slot is not a stop bit");

  // pins beyond the stored strips never toggle
  a_unused_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata & ~LANE_MASK) == 8'h00)
    else $error("unused pin driven high");

  // register port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("cfg_ready low");

endmodule

bind parallel_uart_frame_transposer ufx_checker #(.N_STRIPS(N_STRIPS)) u_ufx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_ready  (cfg_ready)
);
